/* rtl/core/crng_pkg.sv */
// Shared types, constants and the modular fold used by the combined
// congruential generator with shuffle table. No dependencies.
package crng_pkg;

    localparam int GEN_W  = 31;
    localparam int MULT_W = 16;
    localparam int FOLD_W = 8;
    localparam int PROD_W = GEN_W + MULT_W;

    localparam logic [GEN_W-1:0]  MOD1       = 31'd2147483563;
    localparam logic [GEN_W-1:0]  MOD2       = 31'd2147483399;
    localparam logic [MULT_W-1:0] MULT1      = 16'd40014;
    localparam logic [MULT_W-1:0] MULT2      = 16'd40692;
    // 2^31 is congruent to these values modulo MOD1 and MOD2.
    localparam logic [FOLD_W-1:0] FOLD1      = 8'd85;
    localparam logic [FOLD_W-1:0] FOLD2      = 8'd249;
    localparam logic [GEN_W-1:0]  SAMPLE_MAX = 31'd2147483562;
    localparam logic [GEN_W-1:0]  GEN1_RESET = 31'd1;
    localparam logic [GEN_W-1:0]  GEN2_RESET = 31'd123456789;

    typedef struct packed {
        logic load_seed;  // both generators take the seed
        logic step_mul;   // register both raw products
        logic gen1_upd;   // first generator takes its reduced product
        logic gen2_upd;   // second generator takes its reduced product
        logic tbl_rd;     // read the table at the slot of the last output
        logic fill_wr;    // write the reduced first product at the fill address
        logic fill_last;  // the last output takes the reduced first product
        logic finish;     // write back the slot, update last output, present the beat
    } crng_cmd_t;

    typedef struct packed {
        logic out_blocked;  // a result beat is still waiting for the receiver
    } crng_status_t;

    // Reduce a product of a 31-bit value and a 16-bit multiplier modulo a
    // modulus of the form 2^31 - fold. One fold leaves a value below twice
    // the modulus, so one conditional subtract finishes the job.
    function automatic logic [GEN_W-1:0] mod_reduce(
        input logic [PROD_W-1:0] p,
        input logic [FOLD_W-1:0] fold,
        input logic [GEN_W-1:0]  m
    );
        logic [MULT_W+FOLD_W-1:0] hi_fold;
        logic [GEN_W:0]           t;
        hi_fold = p[PROD_W-1:GEN_W] * fold;
        t = {{(GEN_W+1-MULT_W-FOLD_W){1'b0}}, hi_fold} + {1'b0, p[GEN_W-1:0]};
        if (t >= {1'b0, m}) begin
            t = t - {1'b0, m};
        end
        return t[GEN_W-1:0];
    endfunction

endpackage

/* rtl/core/crng_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module crng_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/crng_ctrl.sv */
// Sequencer for the generator: draw steps, reseed warm-up and table fill.
// Depends on crng_pkg.
module crng_ctrl
    import crng_pkg::*;
#(
    parameter int TABLE_DEPTH  = 32,
    parameter int WARMUP_STEPS = 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_func,
    input  crng_status_t                   status,
    output crng_cmd_t                      cmd,
    output logic [$clog2(TABLE_DEPTH)-1:0] fill_addr
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + WARMUP_STEPS + 1);
    localparam logic [CNT_W-1:0] CNT_START = CNT_W'(TABLE_DEPTH + WARMUP_STEPS - 1);
    localparam logic [CNT_W-1:0] CNT_DEPTH = CNT_W'(TABLE_DEPTH);

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_SEED_MUL = 6'b000010,
        ST_SEED_RED = 6'b000100,
        ST_DRAW_MUL = 6'b001000,
        ST_DRAW_RED = 6'b010000,
        ST_DRAW_OUT = 6'b100000
    } crng_state_t;

    crng_state_t      state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign fill_addr = cnt_reg[ADDR_W-1:0];

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_func) begin
                        cmd.load_seed = 1'b1;
                        cnt_next      = CNT_START;
                        state_next    = ST_SEED_MUL;
                    end else begin
                        cmd.step_mul = 1'b1;
                        cmd.tbl_rd   = 1'b1;
                        state_next   = ST_DRAW_RED;
                    end
                end
            end
            ST_SEED_MUL: begin
                cmd.step_mul = 1'b1;
                state_next   = ST_SEED_RED;
            end
            ST_SEED_RED: begin
                cmd.gen1_upd = 1'b1;
                cmd.fill_wr  = (cnt_reg < CNT_DEPTH);
                if (cnt_reg == '0) begin
                    cmd.fill_last = 1'b1;
                    state_next    = ST_DRAW_MUL;
                end else begin
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = ST_SEED_MUL;
                end
            end
            ST_DRAW_MUL: begin
                cmd.step_mul = 1'b1;
                cmd.tbl_rd   = 1'b1;
                state_next   = ST_DRAW_RED;
            end
            ST_DRAW_RED: begin
                cmd.gen1_upd = 1'b1;
                cmd.gen2_upd = 1'b1;
                state_next   = ST_DRAW_OUT;
            end
            ST_DRAW_OUT: begin
                if (!status.out_blocked) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/crng_dp.sv */
// Datapath: both generators, their modular multipliers, the shuffle table
// with valid bits, the last output and the result register.
// Depends on crng_pkg and crng_ram.
module crng_dp
    import crng_pkg::*;
#(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  crng_cmd_t                      cmd,
    input  logic [$clog2(TABLE_DEPTH)-1:0] fill_addr,
    output crng_status_t                   status,
    input  logic [GEN_W-1:0]               s_seed_value,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [GEN_W-1:0]               m_sample
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int unsigned SLOT_SPAN = 1 + int'(SAMPLE_MAX) / TABLE_DEPTH;

    logic [GEN_W-1:0]       gen1_reg, gen1_next;
    logic [GEN_W-1:0]       gen2_reg, gen2_next;
    logic [GEN_W-1:0]       last_reg, last_next;
    logic [PROD_W-1:0]      prod1_reg, prod2_reg;
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic                   rd_valid_reg;
    logic                   m_valid_reg, m_valid_next;
    logic [GEN_W-1:0]       m_sample_reg;

    logic [GEN_W-1:0]  red1, red2, seed_fixed, tbl_data, ram_rdata, mixed, wdata;
    logic [GEN_W:0]    diff;
    logic [ADDR_W-1:0] slot, waddr;
    logic              we;

    assign red1       = mod_reduce(prod1_reg, FOLD1, MOD1);
    assign red2       = mod_reduce(prod2_reg, FOLD2, MOD2);
    assign seed_fixed = (s_seed_value == '0) ? GEN1_RESET : s_seed_value;

    // Slot of the last output: the count of span boundaries at or below it.
    always_comb begin
        slot = '0;
        for (int k = 1; k < TABLE_DEPTH; k++) begin
            if (last_reg >= GEN_W'(k * SLOT_SPAN)) begin
                slot = ADDR_W'(k);
            end
        end
    end

    assign we    = cmd.fill_wr | cmd.finish;
    assign waddr = cmd.fill_wr ? fill_addr : slot;
    assign wdata = cmd.fill_wr ? red1 : gen1_reg;

    crng_ram #(
        .WIDTH(GEN_W),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .aclk (aclk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .re   (cmd.tbl_rd),
        .raddr(slot),
        .rdata(ram_rdata)
    );

    // A slot never written since reset reads as zero.
    assign tbl_data = rd_valid_reg ? ram_rdata : '0;
    assign diff     = {1'b0, tbl_data} - {1'b0, gen2_reg};
    always_comb begin
        if (diff[GEN_W] || (diff == '0)) begin
            mixed = GEN_W'(diff + {1'b0, SAMPLE_MAX});
        end else begin
            mixed = diff[GEN_W-1:0];
        end
    end

    always_comb begin
        gen1_next = gen1_reg;
        gen2_next = gen2_reg;
        last_next = last_reg;
        if (cmd.load_seed) begin
            gen1_next = seed_fixed;
            gen2_next = seed_fixed;
        end
        if (cmd.gen1_upd) begin
            gen1_next = red1;
        end
        if (cmd.gen2_upd) begin
            gen2_next = red2;
        end
        if (cmd.fill_last) begin
            last_next = red1;
        end
        if (cmd.finish) begin
            last_next = mixed;
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (we) begin
            valid_next[waddr] = 1'b1;
        end
    end

    assign status.out_blocked = m_valid_reg & ~m_ready;
    assign m_valid_next       = cmd.finish | (m_valid_reg & ~m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gen1_reg    <= GEN1_RESET;
            gen2_reg    <= GEN2_RESET;
            last_reg    <= '0;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            gen1_reg    <= gen1_next;
            gen2_reg    <= gen2_next;
            last_reg    <= last_next;
            valid_reg   <= valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.step_mul) begin
            prod1_reg <= PROD_W'(gen1_reg) * PROD_W'(MULT1);
            prod2_reg <= PROD_W'(gen2_reg) * PROD_W'(MULT2);
        end
        if (cmd.tbl_rd) begin
            rd_valid_reg <= valid_reg[slot];
        end
        if (cmd.finish) begin
            m_sample_reg <= mixed;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_sample = m_sample_reg;

endmodule

/* rtl/core/combined_lcg_shuffle_rng_top.sv */
// Top level of the combined congruential generator with shuffle table.
// Depends on crng_pkg, crng_ctrl, crng_dp and crng_ram.
//
// Usage: every beat on the s_ channel requests one sample. With s_func low
// the generator draws the next sample; with s_func high it first reseeds
// from s_seed_value (zero is taken as one), runs WARMUP_STEPS warm-up steps
// of the first generator, fills the shuffle table with TABLE_DEPTH more
// steps, and then draws. Each request yields exactly one beat on the m_
// channel carrying m_sample in 1..2147483562; the uniform value is
// m_sample / 2147483563, which the consumer converts and clamps.
// Order of a draw: the accepting edge registers both raw products and the
// table read, the generators then take their folded products, and the
// mixed sample is registered once no earlier beat waits for the receiver.
// A new request is taken once the previous result is registered. A reseed
// runs each step of the first generator through a multiply state and a
// reduce state, and then starts the draw.
// The result register holds a beat while the receiver stalls; the block
// then waits with the next result until that beat is taken.
// Reset (synchronous, active low) restores the generator state: first
// generator one, second generator 123456789, last output zero and an empty
// table, whose slots read as zero until written.
module combined_lcg_shuffle_rng_top
    import crng_pkg::*;
#(
    parameter int TABLE_DEPTH  = 32,
    parameter int WARMUP_STEPS = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_func,
    input  logic [GEN_W-1:0] s_seed_value,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [GEN_W-1:0] m_sample
);

    crng_cmd_t                      cmd;
    crng_status_t                   status;
    logic [$clog2(TABLE_DEPTH)-1:0] fill_addr;

    // The controller owns the request handshake and sequences the steps.
    crng_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .WARMUP_STEPS(WARMUP_STEPS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_func   (s_func),
        .status   (status),
        .cmd      (cmd),
        .fill_addr(fill_addr)
    );

    // The datapath holds all generator state and the result register.
    crng_dp #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .fill_addr   (fill_addr),
        .status      (status),
        .s_seed_value(s_seed_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_sample    (m_sample)
    );

endmodule

/* rtl/core/crng_checker.sv */
// Port-level checks for the generator top level, bound to it below.
// Depends on crng_pkg and combined_lcg_shuffle_rng_top.
module crng_checker
    import crng_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic             m_valid,
    input logic             m_ready,
    input logic [GEN_W-1:0] m_sample
);

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && m_valid && !m_ready) |=> (m_valid && $stable(m_sample)))
        else $error("result beat changed while stalled");

    // Every sample lies in 1..SAMPLE_MAX.
    a_sample_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_sample != '0) && (m_sample <= SAMPLE_MAX)))
        else $error("sample out of range");

    // One request at a time: the request side closes after an accepted beat.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while previous one in progress");

    // Reset empties the result register.
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat present after reset");

endmodule

bind combined_lcg_shuffle_rng_top crng_checker u_crng_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_sample(m_sample)
);

/* tb/sv/combined_lcg_shuffle_rng_top_tb.sv */
// Self-checking testbench for combined_lcg_shuffle_rng_top: a behavioral model of the
// combined generator and shuffle table predicts every sample beat, and random stalls hit
// both channels. Depends on crng_pkg and the RTL of the block.
module combined_lcg_shuffle_rng_top_tb;
    import crng_pkg::*;

    localparam int TABLE_DEPTH  = 32;
    localparam int WARMUP_STEPS = 8;
    // Width of one table slot in sample space; the last output divided by this
    // picks the slot that the next draw reads.
    localparam longint unsigned SLOT_SPAN = 1 + longint'(SAMPLE_MAX) / TABLE_DEPTH;
    localparam int RANDOM_ITEMS = 750;

    logic             aclk         = 1'b0;
    logic             aresetn      = 1'b0;
    logic             s_valid      = 1'b0;
    logic             s_ready;
    logic             s_func       = 1'b0;
    logic [GEN_W-1:0] s_seed_value = '0;
    logic             m_valid;
    logic             m_ready      = 1'b0;
    logic [GEN_W-1:0] m_sample;

    // Model state of the generator, kept in step with the accepted requests.
    logic [GEN_W-1:0] model_gen1;
    logic [GEN_W-1:0] model_gen2;
    logic [GEN_W-1:0] model_last;
    logic [GEN_W-1:0] model_table [TABLE_DEPTH];

    // Samples predicted for requests that have been sent, oldest first.
    logic [GEN_W-1:0] pending_samples [$];

    int error_count = 0;
    // Percentage of cycles in which each side holds back; it drops to zero
    // for one long stretch of the random traffic.
    int idle_pct = 29;

    combined_lcg_shuffle_rng_top #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .WARMUP_STEPS (WARMUP_STEPS)
    ) u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_seed_value (s_seed_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample     (m_sample)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    function automatic logic [GEN_W-1:0] mul_mod(input logic [GEN_W-1:0] x,
                                                  input logic [MULT_W-1:0] a,
                                                  input logic [GEN_W-1:0] m);
        longint unsigned prod;
        prod = longint'(x) * longint'(a);
        return GEN_W'(prod % longint'(m));
    endfunction

    function automatic void clear_model();
        model_gen1 = GEN1_RESET;
        model_gen2 = GEN2_RESET;
        model_last = '0;
        foreach (model_table[i]) model_table[i] = '0;
    endfunction

    // Advances the model by one request and returns the sample it yields.
    function automatic logic [GEN_W-1:0] next_sample(input logic func,
                                                      input logic [GEN_W-1:0] seed);
        logic [GEN_W-1:0] start;
        longint           mixed;
        longint unsigned  slot;
        int               i;
        if (func) begin
            // A zero seed is taken as one. The warm-up steps come first and the
            // table fills from the top slot down, so slot 0 gets the last step.
            start = (seed == '0) ? GEN_W'(1) : seed;
            model_gen1 = start;
            model_gen2 = start;
            for (i = TABLE_DEPTH + WARMUP_STEPS - 1; i >= 0; i--) begin
                model_gen1 = mul_mod(model_gen1, MULT1, MOD1);
                if (i < TABLE_DEPTH) begin
                    model_table[i] = model_gen1;
                end
            end
            model_last = model_table[0];
        end
        model_gen1 = mul_mod(model_gen1, MULT1, MOD1);
        model_gen2 = mul_mod(model_gen2, MULT2, MOD2);
        slot = longint'(model_last) / SLOT_SPAN;
        if (slot >= TABLE_DEPTH) begin
            slot = TABLE_DEPTH - 1;
        end
        mixed = longint'(model_table[slot]) - longint'(model_gen2);
        model_table[slot] = model_gen1;
        if (mixed < 1) begin
            mixed += longint'(SAMPLE_MAX);
        end
        model_last = GEN_W'(mixed);
        return model_last;
    endfunction

    // Sends one request beat. Valid is only lowered during an idle cycle, so a
    // back-to-back request keeps valid high without a second assignment in
    // the same time step. The prediction is queued before the handshake; the
    // result can only come after it, so the order is kept.
    task automatic send_request(input logic func, input logic [GEN_W-1:0] seed);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            s_func  <= 1'($urandom);
            @(posedge aclk);
        end
        pending_samples.push_back(next_sample(func, seed));
        s_valid      <= 1'b1;
        s_func       <= func;
        s_seed_value <= seed;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Releases the request channel and waits until every predicted sample
    // has been returned and checked.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_samples.size() != 0) @(posedge aclk);
    endtask

    // Draws straight out of reset read the zeroed table: the first picks slot 0,
    // and a difference from an unwritten slot wraps back into range.
    task automatic test_unseeded_draws();
        send_request(1'b0, '0);
        send_request(1'b0, SAMPLE_MAX);
        send_request(1'b0, 31'h2AAAAAAA);
        send_request(1'b0, 31'h55555555);
        wait_for_results();
    endtask

    // Seeds at the edges of the range, a zero seed that must behave like one,
    // seeds just around the second modulus and alternating bit patterns.
    task automatic test_seed_extremes();
        send_request(1'b1, '0);
        send_request(1'b0, '0);
        send_request(1'b1, GEN_W'(1));
        send_request(1'b0, SAMPLE_MAX);
        send_request(1'b1, SAMPLE_MAX);
        send_request(1'b0, '0);
        send_request(1'b1, MOD2 - GEN_W'(1));
        send_request(1'b1, MOD2 + GEN_W'(1));
        send_request(1'b1, 31'h2AAAAAAA);
        send_request(1'b1, 31'h55555555);
        send_request(1'b0, 31'h7FFF0000);
        wait_for_results();
    endtask

    // A seed equal to the second modulus pins the second generator at zero;
    // the draws that follow must carry on with that value.
    task automatic test_stuck_second_gen();
        send_request(1'b1, MOD2);
        repeat (5) send_request(1'b0, GEN_W'($urandom_range(0, SAMPLE_MAX)));
        wait_for_results();
    endtask

    // Mostly plain draws with a reseed now and then, most reseeds followed by
    // a run of draws that walks the fresh table. Some seeds are the special
    // values, the rest random over the whole range. One stretch in the middle
    // runs without any idling on either side.
    task automatic test_random_traffic();
        logic             func;
        logic [GEN_W-1:0] seed;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            idle_pct = (n >= 300 && n < 450) ? 0 : 29;
            func = ($urandom_range(0, 99) < 8);
            if ($urandom_range(0, 7) == 0) begin
                case ($urandom_range(0, 4))
                    0: seed = '0;
                    1: seed = GEN_W'(1);
                    2: seed = MOD2;
                    3: seed = SAMPLE_MAX;
                    default: seed = MOD2 + GEN_W'($urandom_range(1, 163));
                endcase
            end else begin
                seed = GEN_W'($urandom_range(0, SAMPLE_MAX));
            end
            send_request(func, seed);
        end
        idle_pct = 29;
        wait_for_results();
    endtask

    // Result side: the ready is stalled at random, and every accepted beat is
    // compared with the oldest prediction. Inputs change only in the NBA
    // region, so the values seen here are those that stood at the edge.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= idle_pct);
        if (aresetn && m_valid && m_ready) begin
            if (pending_samples.size() == 0) begin
                report_mismatch($sformatf("unexpected sample beat 0x%08h", m_sample));
            end else begin
                if (m_sample !== pending_samples[0]) begin
                    report_mismatch($sformatf("sample 0x%08h, expected 0x%08h",
                                              m_sample, pending_samples[0]));
                end
                void'(pending_samples.pop_front());
            end
        end
    end

    initial begin
        clear_model();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_unseeded_draws();
        test_seed_extremes();
        test_stuck_second_gen();
        test_random_traffic();

        // Leave room for any stray beat to show up.
        repeat (20) @(posedge aclk);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run of all requests.
    initial begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/crng_pkg.sv
rtl/core/crng_ram.sv
rtl/core/crng_ctrl.sv
rtl/core/crng_dp.sv
rtl/core/combined_lcg_shuffle_rng_top.sv
rtl/core/crng_checker.sv
tb/sv/combined_lcg_shuffle_rng_top_tb.sv
